// ===== rtl/core/ycc_pkg.sv =====
// Shared constants, types and helpers for the YCbCr to ARGB converter.
// No dependencies; used by ycc_lane and ycbcr_to_argb_convert.
`timescale 1ns / 1ps

package ycc_pkg;

	localparam int LANES     = 4;
	localparam int CH_W      = 8;
	localparam int DIFF_W    = CH_W + 1;
	localparam int FRAC_BITS = 14;
	localparam int COEF_W    = 16;
	localparam int ACC_W     = 24;
	localparam int PROD_W    = COEF_W + DIFF_W;
	localparam int PIX_W     = 3 * CH_W;

	// Q2.14 coefficients, kept with a zero sign bit for signed products.
	localparam logic signed [COEF_W-1:0] COEF_CR_R = 16'sd22970;
	localparam logic signed [COEF_W-1:0] COEF_CB_B = 16'sd29118;
	localparam logic signed [COEF_W-1:0] COEF_CB_G = 16'sd6256;
	localparam logic signed [COEF_W-1:0] COEF_CR_G = 16'sd11700;

	localparam logic signed [ACC_W-1:0] HALF_LSB = 24'sd8192;
	localparam logic [CH_W-1:0] CHROMA_OFFSET = 8'd128;

	typedef logic [CH_W-1:0]          chan_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [PIX_W-1:0]         pixel_t;

	// Takes a rounded Q.14 sum to an 8-bit channel, clamped to 0..255.
	// The integer part sits in bits 23..14; bit 22 set on a positive sum
	// means the value is 256 or more.
	function automatic chan_t sat_chan(input acc_t acc);
		chan_t res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (acc[ACC_W-2]) begin
			res = '1;
		end else begin
			res = acc[FRAC_BITS +: CH_W];
		end
		return res;
	endfunction

endpackage

// ===== rtl/core/ycc_lane.sv =====
// Four-stage datapath that converts one YCbCr pixel to packed RGB.
// Depends on ycc_pkg for widths, coefficients and the clamp helper.
`timescale 1ns / 1ps

module ycc_lane (
	input  logic            clk,
	input  ycc_pkg::chan_t  luma,
	input  ycc_pkg::chan_t  blue_diff,
	input  ycc_pkg::chan_t  red_diff,
	output ycc_pkg::pixel_t pixel
);

	ycc_pkg::chan_t y_s1, y_s2;
	ycc_pkg::diff_t db_s1, dr_s1;
	ycc_pkg::acc_t  pr_s2, pb_s2, pgb_s2, pgr_s2;
	ycc_pkg::acc_t  r_s3, g_s3, b_s3;
	ycc_pkg::pixel_t pixel_s4;

	logic signed [ycc_pkg::PROD_W-1:0] pr_full, pb_full, pgb_full, pgr_full;
	ycc_pkg::acc_t base;

	// Stage 1: capture and remove the chroma offset.
	always_ff @(posedge clk) begin
		y_s1  <= luma;
		db_s1 <= $signed({1'b0, blue_diff}) - $signed({1'b0, ycc_pkg::CHROMA_OFFSET});
		dr_s1 <= $signed({1'b0, red_diff}) - $signed({1'b0, ycc_pkg::CHROMA_OFFSET});
	end

	// Stage 2: one product per coefficient; every product fits 24 bits.
	assign pr_full  = ycc_pkg::COEF_CR_R * dr_s1;
	assign pb_full  = ycc_pkg::COEF_CB_B * db_s1;
	assign pgb_full = ycc_pkg::COEF_CB_G * db_s1;
	assign pgr_full = ycc_pkg::COEF_CR_G * dr_s1;

	always_ff @(posedge clk) begin
		y_s2   <= y_s1;
		pr_s2  <= pr_full[ycc_pkg::ACC_W-1:0];
		pb_s2  <= pb_full[ycc_pkg::ACC_W-1:0];
		pgb_s2 <= pgb_full[ycc_pkg::ACC_W-1:0];
		pgr_s2 <= pgr_full[ycc_pkg::ACC_W-1:0];
	end

	// Stage 3: accumulate with the rounding half added in.
	assign base = $signed({2'b00, y_s2, {ycc_pkg::FRAC_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		r_s3 <= base + pr_s2 + ycc_pkg::HALF_LSB;
		b_s3 <= base + pb_s2 + ycc_pkg::HALF_LSB;
		g_s3 <= base - pgb_s2 - pgr_s2 + ycc_pkg::HALF_LSB;
	end

	// Stage 4: clamp and pack as RRGGBB.
	always_ff @(posedge clk) begin
		pixel_s4 <= {ycc_pkg::sat_chan(r_s3), ycc_pkg::sat_chan(g_s3),
			ycc_pkg::sat_chan(b_s3)};
	end

	assign pixel = pixel_s4;

endmodule

// ===== rtl/core/ycbcr_to_argb_convert.sv =====
// Top level of the YCbCr to ARGB converter: port mapping and item valid chain.
// Depends on ycc_pkg and ycc_lane.
// An accepted item passes through the four register stages of each lane, and its
// result shows with done high once the valid bit reaches the fourth stage.
// Throughput: one item of four pixels per cycle; busy is always low, since
// every lane is a fully pipelined multiply-add path and the receiver cannot stall.
// Reset clears only the valid chain; no item is in flight afterward.
`timescale 1ns / 1ps

module ycbcr_to_argb_convert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ycc_pkg::CH_W-1:0]      luma_0,
	input  logic [ycc_pkg::CH_W-1:0]      luma_1,
	input  logic [ycc_pkg::CH_W-1:0]      luma_2,
	input  logic [ycc_pkg::CH_W-1:0]      luma_3,
	input  logic [ycc_pkg::CH_W-1:0]      blue_diff_0,
	input  logic [ycc_pkg::CH_W-1:0]      blue_diff_1,
	input  logic [ycc_pkg::CH_W-1:0]      blue_diff_2,
	input  logic [ycc_pkg::CH_W-1:0]      blue_diff_3,
	input  logic [ycc_pkg::CH_W-1:0]      red_diff_0,
	input  logic [ycc_pkg::CH_W-1:0]      red_diff_1,
	input  logic [ycc_pkg::CH_W-1:0]      red_diff_2,
	input  logic [ycc_pkg::CH_W-1:0]      red_diff_3,
	output logic                          done,
	output logic [ycc_pkg::PIX_W-1:0]     pixel_out_0,
	output logic [ycc_pkg::PIX_W-1:0]     pixel_out_1,
	output logic [ycc_pkg::PIX_W-1:0]     pixel_out_2,
	output logic [ycc_pkg::PIX_W-1:0]     pixel_out_3
);

	ycc_pkg::chan_t  y_in  [ycc_pkg::LANES];
	ycc_pkg::chan_t  cb_in [ycc_pkg::LANES];
	ycc_pkg::chan_t  cr_in [ycc_pkg::LANES];
	ycc_pkg::pixel_t pix   [ycc_pkg::LANES];

	logic vld_s1, vld_s2, vld_s3, vld_s4;

	assign busy = 1'b0;

	assign y_in[0]  = luma_0;
	assign y_in[1]  = luma_1;
	assign y_in[2]  = luma_2;
	assign y_in[3]  = luma_3;
	assign cb_in[0] = blue_diff_0;
	assign cb_in[1] = blue_diff_1;
	assign cb_in[2] = blue_diff_2;
	assign cb_in[3] = blue_diff_3;
	assign cr_in[0] = red_diff_0;
	assign cr_in[1] = red_diff_1;
	assign cr_in[2] = red_diff_2;
	assign cr_in[3] = red_diff_3;

	for (genvar i = 0; i < ycc_pkg::LANES; i++) begin : g_lane
		ycc_lane u_lane (
			.clk       (clk),
			.luma      (y_in[i]),
			.blue_diff (cb_in[i]),
			.red_diff  (cr_in[i]),
			.pixel     (pix[i])
		);
	end

	// The valid bit walks alongside the lane registers, one stage per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign done        = vld_s4;
	assign pixel_out_0 = pix[0];
	assign pixel_out_1 = pix[1];
	assign pixel_out_2 = pix[2];
	assign pixel_out_3 = pix[3];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for ycbcr_to_argb_convert: drives four-pixel items and
// checks each packed result against an in-bench fixed-point color predictor.
// Depends on ycc_pkg and the converter RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int NUM_LANES   = ycc_pkg::LANES;
	localparam int Q_SHIFT     = 14;
	localparam int ROUND_HALF  = 8192;
	localparam int K_CR_TO_R   = 22970;
	localparam int K_CB_TO_B   = 29118;
	localparam int K_CB_TO_G   = 6256;
	localparam int K_CR_TO_G   = 11700;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_LIMIT = 200;

	typedef logic [NUM_LANES-1:0][ycc_pkg::CH_W-1:0]  chan_lanes_t;
	typedef logic [NUM_LANES-1:0][ycc_pkg::PIX_W-1:0] pixel_lanes_t;

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	logic         done;
	chan_lanes_t  luma_v;
	chan_lanes_t  cb_v;
	chan_lanes_t  cr_v;
	pixel_lanes_t pixel_v;

	pixel_lanes_t expected_pixels[$];
	int           fail_count;
	int           items_sent;
	int           results_checked;
	int           clamped_channels;
	bit           burst_mode;

	ycbcr_to_argb_convert dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.luma_0      (luma_v[0]),
		.luma_1      (luma_v[1]),
		.luma_2      (luma_v[2]),
		.luma_3      (luma_v[3]),
		.blue_diff_0 (cb_v[0]),
		.blue_diff_1 (cb_v[1]),
		.blue_diff_2 (cb_v[2]),
		.blue_diff_3 (cb_v[3]),
		.red_diff_0  (cr_v[0]),
		.red_diff_1  (cr_v[1]),
		.red_diff_2  (cr_v[2]),
		.red_diff_3  (cr_v[3]),
		.done        (done),
		.pixel_out_0 (pixel_v[0]),
		.pixel_out_1 (pixel_v[1]),
		.pixel_out_2 (pixel_v[2]),
		.pixel_out_3 (pixel_v[3])
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Round half up, then clamp to the 8-bit channel range.
	function automatic ycc_pkg::chan_t round_clamp(input int acc);
		int q;
		q = (acc + ROUND_HALF) >>> Q_SHIFT;
		if (q < 0) begin
			clamped_channels++;
			return '0;
		end
		if (q > 255) begin
			clamped_channels++;
			return '1;
		end
		return ycc_pkg::chan_t'(q);
	endfunction

	function automatic ycc_pkg::pixel_t convert_lane(input ycc_pkg::chan_t y,
		input ycc_pkg::chan_t cb, input ycc_pkg::chan_t cr);
		int base;
		int dcb;
		int dcr;
		ycc_pkg::chan_t r;
		ycc_pkg::chan_t g;
		ycc_pkg::chan_t b;
		base = int'(y) <<< Q_SHIFT;
		dcb  = int'(cb) - 128;
		dcr  = int'(cr) - 128;
		r = round_clamp(base + K_CR_TO_R * dcr);
		g = round_clamp(base - K_CB_TO_G * dcb - K_CR_TO_G * dcr);
		b = round_clamp(base + K_CB_TO_B * dcb);
		return {r, g, b};
	endfunction

	function automatic pixel_lanes_t convert_item(input chan_lanes_t y, input chan_lanes_t cb,
		input chan_lanes_t cr);
		pixel_lanes_t res;
		for (int k = 0; k < NUM_LANES; k++) begin
			res[k] = convert_lane(y[k], cb[k], cr[k]);
		end
		return res;
	endfunction

	// Sends one item after a random gap; start stays high when the next gap is zero.
	task automatic send_item(input chan_lanes_t y, input chan_lanes_t cb, input chan_lanes_t cr);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		luma_v <= y;
		cb_v   <= cb;
		cr_v   <= cr;
		do begin
			@(posedge clk);
		end while (busy);
		expected_pixels.push_back(convert_item(y, cb, cr));
		items_sent++;
	endtask

	task automatic send_random_item();
		chan_lanes_t y;
		chan_lanes_t cb;
		chan_lanes_t cr;
		for (int k = 0; k < NUM_LANES; k++) begin
			case ($urandom_range(0, 3))
				0: begin
					// Near-neutral chroma exercises rounding close to the luma value.
					y[k]  = ycc_pkg::chan_t'($urandom);
					cb[k] = ycc_pkg::chan_t'($urandom_range(120, 136));
					cr[k] = ycc_pkg::chan_t'($urandom_range(120, 136));
				end
				1: begin
					// Luma near the ends pushes channels into saturation.
					y[k]  = $urandom_range(0, 1) ? ycc_pkg::chan_t'($urandom_range(0, 15))
						: ycc_pkg::chan_t'($urandom_range(240, 255));
					cb[k] = ycc_pkg::chan_t'($urandom);
					cr[k] = ycc_pkg::chan_t'($urandom);
				end
				default: begin
					y[k]  = ycc_pkg::chan_t'($urandom);
					cb[k] = ycc_pkg::chan_t'($urandom);
					cr[k] = ycc_pkg::chan_t'($urandom);
				end
			endcase
		end
		send_item(y, cb, cr);
	endtask

	task automatic wait_for_results();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_pixels.size() != 0) begin
			$error("%0d expected results never arrived", expected_pixels.size());
			fail_count++;
			expected_pixels.delete();
		end
	endtask

	// Every combination of luma and chroma at their ends, plus the mid points.
	task automatic test_channel_extremes();
		chan_lanes_t y;
		chan_lanes_t cb;
		chan_lanes_t cr;
		for (int combo = 0; combo < 8; combo += NUM_LANES) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				y[k]  = ((combo + k) & 1) ? 8'hFF : 8'h00;
				cb[k] = ((combo + k) & 2) ? 8'hFF : 8'h00;
				cr[k] = ((combo + k) & 4) ? 8'hFF : 8'h00;
			end
			send_item(y, cb, cr);
		end
		send_item('0, '0, '0);
		send_item('1, '1, '1);
		send_item({8'd128, 8'd127, 8'd129, 8'd128}, {8'd0, 8'd255, 8'd128, 8'd1},
			{8'd255, 8'd0, 8'd1, 8'd128});
	endtask

	// With neutral chroma every channel equals the luma.
	task automatic test_neutral_chroma();
		send_item({8'd0, 8'd1, 8'd254, 8'd255}, {4{8'd128}}, {4{8'd128}});
		send_item({8'd64, 8'd127, 8'd128, 8'd200}, {4{8'd128}}, {4{8'd128}});
	endtask

	// One set bit walks through every field, so each bit is seen high and low.
	task automatic test_bit_walk();
		for (int b = 0; b < ycc_pkg::CH_W; b++) begin
			send_item({4{8'(1 << b)}}, {4{~8'(1 << b)}}, {4{8'(1 << b)}});
		end
	endtask

	// Random items in phases of 100, each phase set at random to bursts or random
	// gaps, with a full drain pause in the middle of the run.
	task automatic test_random_stream();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				burst_mode = ($urandom_range(0, 2) == 0);
			end
			if (n == RANDOM_ITEMS / 2) begin
				wait_for_results();
			end
			send_random_item();
		end
		burst_mode = 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		pixel_lanes_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$error("result strobe with no item outstanding");
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				results_checked++;
				for (int k = 0; k < NUM_LANES; k++) begin
					if (pixel_v[k] !== want[k]) begin
						$error("pixel_out_%0d: expected %06h, got %06h", k, want[k], pixel_v[k]);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		fail_count       = 0;
		items_sent       = 0;
		results_checked  = 0;
		clamped_channels = 0;
		burst_mode       = 1'b0;
		arst_n = 1'b0;
		start  = 1'b0;
		luma_v = '0;
		cb_v   = '0;
		cr_v   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_channel_extremes();
		test_neutral_chroma();
		test_bit_walk();
		test_random_stream();

		wait_for_results();
		// Catch any stray strobe after the last expected result.
		repeat (8) @(posedge clk);

		$display("Sent %0d items and checked %0d four-pixel results;", items_sent,
			results_checked);
		$display("%0d predicted channels were clamped to 0 or 255.", clamped_channels);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
